// ----- design/ffm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_pkg
// Shared widths, constants and pipeline word types of the frame freeze
// monitor.
// ----------------------------------------------------------------------------
package ffm_pkg;

   localparam int LUMA_W   = 8;
   localparam int SUM_W    = 23;
   localparam int COUNT_W  = 16;
   localparam int SEQ_W    = 32;
   localparam int TOTAL_W  = 32;
   localparam int DECIM_W  = 8;

   localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
   localparam logic [DECIM_W-1:0] DECIM_RESET = 8'd4;

   // One accepted word as it leaves the address stage.
   typedef struct packed {
      logic [LUMA_W-1:0]  luma;
      logic               compare;
      logic               frame_end;
      logic [COUNT_W-1:0] count;
      logic               compared;
      logic               forward;
      logic [SEQ_W-1:0]   sequence_req;
      logic               short_frame;
   } item_type;

   // Frame summary handed from the difference stage to the statistics stage.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic               compared;
      logic               forward;
      logic [SEQ_W-1:0]   sequence_req;
      logic               short_frame;
   } frame_sum_type;

endpackage
`default_nettype wire

// ----- design/ffm_sample_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_sample_mem
// Single-port sample store of the previous frame, read-first, with a registered
// read port.
// ----------------------------------------------------------------------------
module ffm_sample_mem
   import ffm_pkg::*;
#(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [LUMA_W-1:0] wr_data,
   output logic [LUMA_W-1:0] rd_data
);

   logic [LUMA_W-1:0] sample_mem [DEPTH];
   logic [LUMA_W-1:0] rd_data_ff;

   // The old value is read in the same cycle the new sample replaces it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sample_mem[addr];
      end
      if (wr_en) begin
         sample_mem[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/ffm_diff_acc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_diff_acc
// Difference stage: takes the stored sample from memory, accumulates the
// saturating sum of absolute differences and emits a summary at frame end.
// ----------------------------------------------------------------------------
module ffm_diff_acc
   import ffm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   input  logic [LUMA_W-1:0] rd_data,
   output logic              out_valid,
   input  logic              out_ready,
   output frame_sum_type     out_word
);

   logic              s1_valid_ff;
   item_type          s1_item_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]  acc_in;
   logic [LUMA_W-1:0] abs_diff;
   logic [SUM_W:0]    acc_sum;
   logic [SUM_W-1:0]  acc_sat;
   logic              s1_move;

   always_comb begin
      if (s1_item_ff.luma > rd_data) begin
         abs_diff = s1_item_ff.luma - rd_data;
      end else begin
         abs_diff = rd_data - s1_item_ff.luma;
      end
      acc_sum = {1'b0, acc_ff} + (SUM_W + 1)'(abs_diff);
      acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
      acc_in  = s1_item_ff.compare ? acc_sat : acc_ff;
   end

   assign s1_move   = s1_valid_ff && (!s1_item_ff.frame_end || out_ready);
   assign in_ready  = !s1_valid_ff || s1_move;
   assign out_valid = s1_valid_ff && s1_item_ff.frame_end;

   always_comb begin
      out_word.sum          = s1_item_ff.compared ? acc_in : '0;
      out_word.count        = s1_item_ff.count;
      out_word.compared     = s1_item_ff.compared;
      out_word.forward      = s1_item_ff.forward;
      out_word.sequence_req = s1_item_ff.sequence_req;
      out_word.short_frame  = s1_item_ff.short_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         if (in_valid && in_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            acc_ff <= s1_item_ff.frame_end ? '0 : acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

// ----- design/ffm_frame_stats.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ffm_frame_stats
// Statistics stage: sequence gap, saturating totals, minimum and maximum sum,
// and the result output register.
// ----------------------------------------------------------------------------
module ffm_frame_stats
   import ffm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  frame_sum_type      in_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SUM_W-1:0]   rsp_sad_sum,
   output logic [COUNT_W-1:0] rsp_sample_count,
   output logic               rsp_compared,
   output logic               rsp_frozen,
   output logic               rsp_forward,
   output logic [SEQ_W-1:0]   rsp_gap_frames,
   output logic [TOTAL_W-1:0] rsp_drop_total,
   output logic [TOTAL_W-1:0] rsp_frozen_total,
   output logic [TOTAL_W-1:0] rsp_short_total,
   output logic [SUM_W-1:0]   rsp_sad_min,
   output logic [SUM_W-1:0]   rsp_sad_max
);

   logic               s2_valid_ff;
   frame_sum_type      s2_word_ff;
   logic               s2_move;

   logic [SEQ_W-1:0]   last_seq_ff;
   logic               have_seq_ff;
   logic [TOTAL_W-1:0] drops_ff;
   logic [TOTAL_W-1:0] frozen_cnt_ff;
   logic [TOTAL_W-1:0] short_cnt_ff;
   logic [SUM_W-1:0]   min_ff;
   logic [SUM_W-1:0]   max_ff;

   logic [TOTAL_W-1:0] drops_in;
   logic [TOTAL_W-1:0] frozen_cnt_in;
   logic [TOTAL_W-1:0] short_cnt_in;
   logic [SUM_W-1:0]   min_in;
   logic [SUM_W-1:0]   max_in;
   logic [SEQ_W-1:0]   gap;
   logic               frozen;
   logic [SEQ_W:0]     last_plus_one;
   logic [TOTAL_W:0]   drops_sum;

   logic               out_valid_ff;
   logic [SUM_W-1:0]   sad_sum_ff;
   logic [COUNT_W-1:0] sample_count_ff;
   logic               compared_ff;
   logic               frozen_ff;
   logic               forward_ff;
   logic [SEQ_W-1:0]   gap_ff;

   assign s2_move  = s2_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_ready = !s2_valid_ff || s2_move;

   always_comb begin
      frozen        = s2_word_ff.compared && (s2_word_ff.sum == '0);
      // A gap counts only when the new number lies beyond the last one plus
      // one without wrapping.
      last_plus_one = {1'b0, last_seq_ff} + (SEQ_W + 1)'(1);
      if (have_seq_ff && ({1'b0, s2_word_ff.sequence_req} > last_plus_one)) begin
         gap = s2_word_ff.sequence_req - last_seq_ff - SEQ_W'(1);
      end else begin
         gap = '0;
      end
      drops_sum = {1'b0, drops_ff} + (TOTAL_W + 1)'(gap);
      drops_in  = drops_sum[TOTAL_W] ? TOTAL_MAX : drops_sum[TOTAL_W-1:0];

      short_cnt_in = short_cnt_ff;
      if (s2_word_ff.short_frame && (short_cnt_ff != TOTAL_MAX)) begin
         short_cnt_in = short_cnt_ff + TOTAL_W'(1);
      end
      frozen_cnt_in = frozen_cnt_ff;
      if (frozen && (frozen_cnt_ff != TOTAL_MAX)) begin
         frozen_cnt_in = frozen_cnt_ff + TOTAL_W'(1);
      end

      min_in = min_ff;
      max_in = max_ff;
      if (s2_word_ff.compared) begin
         if (s2_word_ff.sum < min_ff) begin
            min_in = s2_word_ff.sum;
         end
         if (s2_word_ff.sum > max_ff) begin
            max_in = s2_word_ff.sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_seq_ff   <= '0;
         have_seq_ff   <= 1'b0;
         drops_ff      <= '0;
         frozen_cnt_ff <= '0;
         short_cnt_ff  <= '0;
         min_ff        <= SUM_MAX;
         max_ff        <= '0;
      end else begin
         if (in_valid && in_ready) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            last_seq_ff   <= s2_word_ff.sequence_req;
            have_seq_ff   <= 1'b1;
            drops_ff      <= drops_in;
            frozen_cnt_ff <= frozen_cnt_in;
            short_cnt_ff  <= short_cnt_in;
            min_ff        <= min_in;
            max_ff        <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_word_ff <= in_word;
      end
      if (s2_move) begin
         sad_sum_ff      <= s2_word_ff.sum;
         sample_count_ff <= s2_word_ff.count;
         compared_ff     <= s2_word_ff.compared;
         frozen_ff       <= frozen;
         forward_ff      <= s2_word_ff.forward;
         gap_ff          <= gap;
      end
   end

   // The running totals stay put while a result waits, so they double as the
   // output fields.
   assign rsp_valid        = out_valid_ff;
   assign rsp_sad_sum      = sad_sum_ff;
   assign rsp_sample_count = sample_count_ff;
   assign rsp_compared     = compared_ff;
   assign rsp_frozen       = frozen_ff;
   assign rsp_forward      = forward_ff;
   assign rsp_gap_frames   = gap_ff;
   assign rsp_drop_total   = drops_ff;
   assign rsp_frozen_total = frozen_cnt_ff;
   assign rsp_short_total  = short_cnt_ff;
   assign rsp_sad_min      = min_ff;
   assign rsp_sad_max      = max_ff;

endmodule
`default_nettype wire

// ----- design/video_frame_freeze_monitor.sv -----
`default_nettype none
// A frame-end word's result passes the difference stage, statistics stage and result registers before it is valid.
// Throughput: one luma word per cycle while the result side does not stall; the sample memory's single
// read-first port is read for every accepted word and written for every sampled one, in that cycle.
// Reset is synchronous and clears all control state and totals; the sample memory
// is not cleared, and the first frame after reset only fills it.
// ----------------------------------------------------------------------------
// video_frame_freeze_monitor
// Subsampled frame difference monitor: compares every SAMPLE_STRIDE-th luma
// word against the previous frame and reports per-frame statistics.
// ----------------------------------------------------------------------------
module video_frame_freeze_monitor
   import ffm_pkg::*;
#(
   parameter int SAMPLE_STRIDE = 64,
   parameter int MAX_SAMPLES   = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [DECIM_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [LUMA_W-1:0]  req_luma,
   input  logic               req_frame_end,
   input  logic [SEQ_W-1:0]   req_sequence_req,
   input  logic               req_short_frame,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SUM_W-1:0]   rsp_sad_sum,
   output logic [COUNT_W-1:0] rsp_sample_count,
   output logic               rsp_compared,
   output logic               rsp_frozen,
   output logic               rsp_forward,
   output logic [SEQ_W-1:0]   rsp_gap_frames,
   output logic [TOTAL_W-1:0] rsp_drop_total,
   output logic [TOTAL_W-1:0] rsp_frozen_total,
   output logic [TOTAL_W-1:0] rsp_short_total,
   output logic [SUM_W-1:0]   rsp_sad_min,
   output logic [SUM_W-1:0]   rsp_sad_max
);

   localparam int PHASE_W = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
   localparam int ADDR_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);

   logic [DECIM_W-1:0] decim_ff;
   logic [DECIM_W-1:0] dphase_ff;
   logic [DECIM_W-1:0] dphase_in;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_after;
   logic               have_prev_ff;

   logic               accept;
   logic               sample;
   logic [31:0]        count_wide;
   logic [DECIM_W:0]   dphase_next;
   logic [DECIM_W:0]   factor;
   item_type           item;
   logic [LUMA_W-1:0]  rd_data;

   logic               sum_valid;
   logic               sum_ready;
   frame_sum_type      sum_word;

   assign accept = req_valid && req_ready;
   assign sample = (phase_ff == '0) && (idx_ff < IDX_W'(MAX_SAMPLES));

   always_comb begin
      idx_after  = idx_ff + IDX_W'(sample);
      count_wide = 32'(idx_after);

      if ((32'(phase_ff) + 32'd1) >= 32'(SAMPLE_STRIDE)) begin
         phase_in = '0;
      end else begin
         phase_in = phase_ff + PHASE_W'(1);
      end

      // A factor of zero acts as one.
      factor      = (decim_ff == '0) ? (DECIM_W + 1)'(1) : {1'b0, decim_ff};
      dphase_next = {1'b0, dphase_ff} + (DECIM_W + 1)'(1);
      dphase_in   = (dphase_next >= factor) ? '0 : dphase_next[DECIM_W-1:0];

      item.luma         = req_luma;
      item.compare      = sample && have_prev_ff;
      item.frame_end    = req_frame_end;
      item.count        = have_prev_ff ? count_wide[COUNT_W-1:0] : '0;
      item.compared     = have_prev_ff;
      item.forward      = (dphase_ff == '0);
      item.sequence_req = req_sequence_req;
      item.short_frame  = req_short_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff     <= DECIM_RESET;
         dphase_ff    <= '0;
         phase_ff     <= '0;
         idx_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            decim_ff <= csr_wr_data;
         end
         if (accept) begin
            if (req_frame_end) begin
               phase_ff     <= '0;
               idx_ff       <= '0;
               have_prev_ff <= 1'b1;
               dphase_ff    <= dphase_in;
            end else begin
               phase_ff <= phase_in;
               idx_ff   <= idx_after;
            end
         end
      end
   end

   ffm_sample_mem #(
      .DEPTH  (MAX_SAMPLES),
      .ADDR_W (ADDR_W)
   ) u_sample_mem (
      .clock   (clock),
      .rd_en   (accept),
      .wr_en   (accept && sample),
      .addr    (idx_ff[ADDR_W-1:0]),
      .wr_data (req_luma),
      .rd_data (rd_data)
   );

   ffm_diff_acc u_diff_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (item),
      .rd_data   (rd_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_word  (sum_word)
   );

   ffm_frame_stats u_frame_stats (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (sum_valid),
      .in_ready         (sum_ready),
      .in_word          (sum_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sad_sum      (rsp_sad_sum),
      .rsp_sample_count (rsp_sample_count),
      .rsp_compared     (rsp_compared),
      .rsp_frozen       (rsp_frozen),
      .rsp_forward      (rsp_forward),
      .rsp_gap_frames   (rsp_gap_frames),
      .rsp_drop_total   (rsp_drop_total),
      .rsp_frozen_total (rsp_frozen_total),
      .rsp_short_total  (rsp_short_total),
      .rsp_sad_min      (rsp_sad_min),
      .rsp_sad_max      (rsp_sad_max)
   );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame freeze monitor testbench
// Streams luma words in whole frames through the monitor with random gaps on
// both channels, predicts every frame report in step with the accepted words
// and checks each report field by field. The decimation factor is changed
// between frames while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   import ffm_pkg::*;

   localparam int SAMPLE_STRIDE = 64;
   localparam int MAX_SAMPLES   = 32768;
   // The first frame fills this many sample slots; no later frame may use more,
   // or it would compare against slots that were never written.
   localparam int PRIME_SAMPLES = 8;
   localparam int MAX_FRAME_LEN = PRIME_SAMPLES * SAMPLE_STRIDE;
   localparam int IDLE_MAX      = 18;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_WORDS  = 900;
   localparam int MIN_FRAMES    = 80;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef enum {FRAME_RANDOM, FRAME_FROZEN, FRAME_EXTREME, FRAME_ZERO, FRAME_FULL}
      frame_kind_type;

   typedef struct {
      logic [LUMA_W-1:0] luma;
      logic              frame_end;
      logic [SEQ_W-1:0]  seq;
      logic              short_frame;
   } luma_word_type;

   typedef struct {
      logic [SUM_W-1:0]   sad_sum;
      logic [COUNT_W-1:0] sample_count;
      logic               compared;
      logic               frozen;
      logic               forward;
      logic [SEQ_W-1:0]   gap_frames;
      logic [TOTAL_W-1:0] drop_total;
      logic [TOTAL_W-1:0] frozen_total;
      logic [TOTAL_W-1:0] short_total;
      logic [SUM_W-1:0]   sad_min;
      logic [SUM_W-1:0]   sad_max;
   } frame_report_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic [DECIM_W-1:0] csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [LUMA_W-1:0]  req_luma         = '0;
   logic               req_frame_end    = 1'b0;
   logic [SEQ_W-1:0]   req_sequence_req = '0;
   logic               req_short_frame  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [SUM_W-1:0]   rsp_sad_sum;
   logic [COUNT_W-1:0] rsp_sample_count;
   logic               rsp_compared;
   logic               rsp_frozen;
   logic               rsp_forward;
   logic [SEQ_W-1:0]   rsp_gap_frames;
   logic [TOTAL_W-1:0] rsp_drop_total;
   logic [TOTAL_W-1:0] rsp_frozen_total;
   logic [TOTAL_W-1:0] rsp_short_total;
   logic [SUM_W-1:0]   rsp_sad_min;
   logic [SUM_W-1:0]   rsp_sad_max;

   video_frame_freeze_monitor #(
      .SAMPLE_STRIDE (SAMPLE_STRIDE),
      .MAX_SAMPLES   (MAX_SAMPLES)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_luma         (req_luma),
      .req_frame_end    (req_frame_end),
      .req_sequence_req (req_sequence_req),
      .req_short_frame  (req_short_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sad_sum      (rsp_sad_sum),
      .rsp_sample_count (rsp_sample_count),
      .rsp_compared     (rsp_compared),
      .rsp_frozen       (rsp_frozen),
      .rsp_forward      (rsp_forward),
      .rsp_gap_frames   (rsp_gap_frames),
      .rsp_drop_total   (rsp_drop_total),
      .rsp_frozen_total (rsp_frozen_total),
      .rsp_short_total  (rsp_short_total),
      .rsp_sad_min      (rsp_sad_min),
      .rsp_sad_max      (rsp_sad_max)
   );

   // Stimulus side.
   luma_word_type    word_queue [$];
   luma_word_type    next_word;
   frame_report_type frame_reports [$];
   logic [LUMA_W-1:0] gen_stored [PRIME_SAMPLES];
   logic [SEQ_W-1:0]  gen_seq = '0;
   int unsigned words_queued  = 0;
   int unsigned words_taken   = 0;
   int unsigned frames_queued = 0;
   int unsigned factor_writes = 0;
   int          send_idle_max = 0;
   int          recv_idle_max = 0;
   int          send_wait     = 0;
   int          recv_wait     = 0;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   logic        req_taken     = 1'b0;
   logic        rsp_taken     = 1'b0;
   int unsigned cycle_count   = 0;
   int unsigned mismatch_count = 0;

   // Predicted block state.
   logic [LUMA_W-1:0]  prev_luma [MAX_SAMPLES];
   logic [5:0]         stride_pos   = '0;
   logic [COUNT_W-1:0] sample_pos   = '0;
   logic [SUM_W-1:0]   diff_sum     = '0;
   logic               seen_frame   = 1'b0;
   logic [SEQ_W-1:0]   seq_last     = '0;
   logic               seq_valid    = 1'b0;
   logic [DECIM_W-1:0] decim_pos    = '0;
   logic [DECIM_W-1:0] decim_factor = DECIM_RESET;
   logic [TOTAL_W-1:0] drops        = '0;
   logic [TOTAL_W-1:0] freezes      = '0;
   logic [TOTAL_W-1:0] shorts       = '0;
   logic [SUM_W-1:0]   sum_low      = SUM_MAX;
   logic [SUM_W-1:0]   sum_high     = '0;
   int unsigned compares_seen  = 0;
   int unsigned forwarded_seen = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [TOTAL_W-1:0] sat_total(logic [TOTAL_W-1:0] a,
                                                    logic [TOTAL_W-1:0] b);
      longint unsigned s;
      s = a + b;
      return (s > TOTAL_MAX) ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   // Advances the predicted state by one accepted word and queues the frame
   // report when the word closes a frame.
   task automatic predict_word(luma_word_type w);
      frame_report_type  r;
      logic [LUMA_W-1:0] old;
      longint unsigned acc;
      int              factor;
      if (stride_pos == 0 && sample_pos < MAX_SAMPLES) begin
         if (seen_frame) begin
            old = prev_luma[sample_pos];
            acc = diff_sum + ((w.luma > old) ? w.luma - old : old - w.luma);
            diff_sum = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
         end
         prev_luma[sample_pos] = w.luma;
         sample_pos++;
      end
      stride_pos = (stride_pos + 1 >= SAMPLE_STRIDE) ? '0 : stride_pos + 1'b1;
      if (w.frame_end) begin
         r.compared     = seen_frame;
         r.sad_sum      = seen_frame ? diff_sum : '0;
         r.sample_count = seen_frame ? sample_pos : '0;
         r.frozen       = seen_frame && r.sad_sum == 0;
         r.forward      = decim_pos == 0;
         factor = (decim_factor == 0) ? 1 : int'(decim_factor);
         // A gap counts only on a forward jump; repeats, steps back and wraps give none.
         r.gap_frames = '0;
         if (seq_valid && {1'b0, w.seq} > {1'b0, seq_last} + 33'd1)
            r.gap_frames = w.seq - seq_last - 1;
         drops     = sat_total(drops, r.gap_frames);
         seq_last  = w.seq;
         seq_valid = 1'b1;
         if (w.short_frame)
            shorts = sat_total(shorts, 1);
         if (r.compared) begin
            compares_seen++;
            if (r.frozen)
               freezes = sat_total(freezes, 1);
            if (r.sad_sum < sum_low)
               sum_low = r.sad_sum;
            if (r.sad_sum > sum_high)
               sum_high = r.sad_sum;
         end
         if (r.forward)
            forwarded_seen++;
         decim_pos = (int'(decim_pos) + 1 >= factor) ? '0 : decim_pos + 1'b1;
         r.drop_total   = drops;
         r.frozen_total = freezes;
         r.short_total  = shorts;
         r.sad_min      = sum_low;
         r.sad_max      = sum_high;
         frame_reports.push_back(r);
         seen_frame = 1'b1;
         stride_pos = '0;
         sample_pos = '0;
         diff_sum   = '0;
      end
   endtask

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_report();
      frame_report_type r;
      if (frame_reports.size() == 0) begin
         $error("frame report arrived with none expected");
         mismatch_count++;
      end else begin
         r = frame_reports.pop_front();
         check_field("sad_sum", r.sad_sum, rsp_sad_sum);
         check_field("sample_count", r.sample_count, rsp_sample_count);
         check_field("compared", r.compared, rsp_compared);
         check_field("frozen", r.frozen, rsp_frozen);
         check_field("forward", r.forward, rsp_forward);
         check_field("gap_frames", r.gap_frames, rsp_gap_frames);
         check_field("drop_total", r.drop_total, rsp_drop_total);
         check_field("frozen_total", r.frozen_total, rsp_frozen_total);
         check_field("short_total", r.short_total, rsp_short_total);
         check_field("sad_min", r.sad_min, rsp_sad_min);
         check_field("sad_max", r.sad_max, rsp_sad_max);
      end
   endtask

   function automatic int draw_wait(int limit);
      if (limit == 0 || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, limit);
   endfunction

   // Monitor: everything is sampled at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready)
         check_report();
      if (!reset && req_valid && req_ready) begin
         words_taken++;
         predict_word('{req_luma, req_frame_end, req_sequence_req, req_short_frame});
      end
   end

   // Driver: presents the next queued word once the current one is taken and
   // its gap has run out.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait--;
         end else if (word_queue.size() != 0) begin
            next_word = word_queue.pop_front();
            req_luma         <= next_word.luma;
            req_frame_end    <= next_word.frame_end;
            req_sequence_req <= next_word.seq;
            req_short_frame  <= next_word.short_frame;
            req_valid        <= 1'b1;
            send_wait = draw_wait(send_idle_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: a random stall after each report, plus the long hold-off on request.
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (rsp_taken)
         recv_wait = draw_wait(recv_idle_max);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (recv_wait > 0) begin
         rsp_ready <= 1'b0;
         recv_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_frame(int len, frame_kind_type kind, logic [SEQ_W-1:0] seq,
                             logic is_short);
      luma_word_type w;
      int            slot;
      for (int i = 0; i < len; i++) begin
         w.luma = LUMA_W'($urandom);
         if (i % SAMPLE_STRIDE == 0) begin
            slot = i / SAMPLE_STRIDE;
            case (kind)
               FRAME_FROZEN:  w.luma = gen_stored[slot];
               FRAME_EXTREME: w.luma = gen_stored[slot][LUMA_W-1] ? '0 : '1;
               FRAME_ZERO:    w.luma = '0;
               FRAME_FULL:    w.luma = '1;
               default: ;
            endcase
            gen_stored[slot] = w.luma;
         end
         // Sequence and short flag only count on the last word; elsewhere they are noise.
         w.frame_end   = (i == len - 1);
         w.seq         = w.frame_end ? seq : $urandom;
         w.short_frame = w.frame_end ? is_short : 1'($urandom_range(0, 1));
         word_queue.push_back(w);
      end
      words_queued += len;
      frames_queued++;
   endtask

   function automatic logic [SEQ_W-1:0] pick_seq();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         gen_seq = gen_seq + 1;
      else if (roll < 80)
         gen_seq = gen_seq + $urandom_range(2, 6);
      else if (roll < 85)
         gen_seq = gen_seq;
      else if (roll < 90)
         gen_seq = gen_seq - $urandom_range(1, 6);
      else
         gen_seq = $urandom;
      return gen_seq;
   endfunction

   function automatic int pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return $urandom_range(1, 3);
      if (roll < 88)
         return $urandom_range(4, 130);
      if (roll < 95)
         return $urandom_range(131, MAX_FRAME_LEN);
      case ($urandom_range(0, 4))
         0:       return SAMPLE_STRIDE;
         1:       return SAMPLE_STRIDE + 1;
         2:       return 2 * SAMPLE_STRIDE;
         3:       return 2 * SAMPLE_STRIDE + 1;
         default: return MAX_FRAME_LEN;
      endcase
   endfunction

   function automatic frame_kind_type pick_kind();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return FRAME_RANDOM;
      if (roll < 7)
         return FRAME_FROZEN;
      if (roll < 8)
         return FRAME_EXTREME;
      return (roll == 8) ? FRAME_ZERO : FRAME_FULL;
   endfunction

   // Returns once every queued word is taken, every report is in, and the
   // pipeline has had time to drain.
   task automatic wait_idle();
      do @(negedge clock);
      while (words_taken != words_queued || frame_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_factor(logic [DECIM_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      decim_factor = value;
      factor_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned random_start;
      int          phase_count;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // The first frame is full length so that every later frame compares
      // only against written slots. It runs at the reset decimation factor.
      push_frame(MAX_FRAME_LEN, FRAME_RANDOM, 32'd0, 1'b0);
      push_frame(1, FRAME_ZERO, 32'hFFFF_FFF0, 1'b1);
      push_frame(1, FRAME_FROZEN, 32'd1, 1'b0);
      push_frame(1, FRAME_FULL, 32'hFFFF_FFFF, 1'b1);
      push_frame(1, FRAME_FROZEN, 32'd0, 1'b0);
      push_frame(1, FRAME_EXTREME, 32'd0, 1'b0);
      push_frame(2, FRAME_RANDOM, 32'd5, 1'b1);
      gen_seq = 32'd5;
      wait_idle();

      // A factor of zero forwards every frame.
      write_factor(8'd0);
      repeat (3) push_frame(1, FRAME_RANDOM, pick_seq(), 1'b0);
      wait_idle();
      write_factor(8'd255);
      repeat (5) push_frame(1, FRAME_FROZEN, pick_seq(), 1'b1);
      wait_idle();
      // Lowering the factor below the current phase must wrap the phase.
      write_factor(8'd3);
      repeat (3) push_frame(1, FRAME_RANDOM, pick_seq(), 1'b0);
      wait_idle();
      write_factor(8'd1);
      repeat (2) push_frame(1, FRAME_EXTREME, pick_seq(), 1'b0);
      wait_idle();

      random_start = words_queued;
      phase_count  = 0;
      while (words_queued - random_start < RANDOM_WORDS || frames_queued < MIN_FRAMES) begin
         phase_count++;
         case ($urandom_range(0, 6))
            0:       write_factor(8'd1);
            1:       write_factor(8'd255);
            2:       write_factor(8'd0);
            3:       write_factor(DECIM_W'($urandom_range(2, 8)));
            4:       write_factor(DECIM_W'($urandom_range(9, 254)));
            default: ;
         endcase
         send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
         recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
         if (phase_count == 3) begin
            // Hold the result side off while short frames stream in back to back.
            send_idle_max = 0;
            @(posedge clock);
            hold_requests++;
            repeat (50) push_frame($urandom_range(1, 2), pick_kind(), pick_seq(),
                                   1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(5, 15))
               push_frame(pick_length(), pick_kind(), pick_seq(),
                          1'($urandom_range(0, 1)));
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d luma words in %0d frames: %0d compared, %0d forwarded.",
               words_taken, frames_queued, compares_seen, forwarded_seen);
      $display("Decimation factor changed %0d times over %0d random phases.",
               factor_writes, phase_count);
      if (mismatch_count == 0 && frame_reports.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles.", cycle_count);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ffm_pkg.sv
design/ffm_sample_mem.sv
design/ffm_diff_acc.sv
design/ffm_frame_stats.sv
design/video_frame_freeze_monitor.sv
test/testbench.sv
